@@ rtl/cfb_pkg.sv @@
package cfb_pkg;

  // Frame constants.
  localparam int unsigned MaxCommands  = 10;
  localparam int unsigned CmdFields    = 10;
  localparam logic [7:0]  StartDelim   = 8'h27;
  localparam logic [7:0]  ClassByte    = 8'h03;
  localparam logic [7:0]  OpSet        = 8'h80;
  localparam logic [7:0]  LenBase      = 8'h05;
  localparam logic [15:0] CrcPoly      = 16'h1021;
  localparam logic [15:0] CrcInit      = 16'hFFFF;
  localparam logic [15:0] CrcXorOut    = 16'hFFFF;
  localparam logic [15:0] DstAddrReset = 16'hF8E7;
  localparam logic [7:0]  SrcAddrReset = 8'h0A;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    RegDstAddr = 1'b0,
    RegSrcAddr = 1'b1
  } cfg_reg_e;

  // Microcode program size.
  localparam int unsigned NumSteps = 11;
  localparam int unsigned PcWidth  = $clog2(NumSteps);

  // Program entry points and the identifier loop.
  localparam logic [PcWidth-1:0] PcFrame  = PcWidth'(0);
  localparam logic [PcWidth-1:0] PcCmd    = PcWidth'(7);
  localparam logic [PcWidth-1:0] PcError  = PcWidth'(10);

  // Source of the byte sent in one step.
  typedef enum logic [3:0] {
    SrcDelim,
    SrcLen,
    SrcDstHi,
    SrcDstLo,
    SrcSrcAddr,
    SrcClass,
    SrcOp,
    SrcCmd,
    SrcCrcHi,
    SrcCrcLo,
    SrcZero
  } src_e;

  // Jump conditions.
  typedef enum logic [0:0] {
    CondNone,
    CondMoreCmds
  } cond_e;

  // One control word.
  typedef struct packed {
    src_e                src;
    logic                crc_en;
    logic                shift;
    logic                last;
    logic                err;
    logic                done;
    cond_e               cond;
    logic [PcWidth-1:0]  target;
  } ctrl_t;

  // The program: one control word per step.
  function automatic ctrl_t ucode_rom(input logic [PcWidth-1:0] pc);
    ctrl_t w;
    w = '{src: SrcZero, crc_en: 1'b0, shift: 1'b0, last: 1'b0, err: 1'b0,
          done: 1'b1, cond: CondNone, target: PcFrame};
    case (pc)
      PcWidth'(0):  w.src = SrcDelim;
      PcWidth'(1):  begin w.src = SrcLen;     w.crc_en = 1'b1; end
      PcWidth'(2):  begin w.src = SrcDstHi;   w.crc_en = 1'b1; end
      PcWidth'(3):  begin w.src = SrcDstLo;   w.crc_en = 1'b1; end
      PcWidth'(4):  begin w.src = SrcSrcAddr; w.crc_en = 1'b1; end
      PcWidth'(5):  begin w.src = SrcClass;   w.crc_en = 1'b1; end
      PcWidth'(6):  begin w.src = SrcOp;      w.crc_en = 1'b1; end
      PcWidth'(7):  begin
        w.src    = SrcCmd;
        w.crc_en = 1'b1;
        w.shift  = 1'b1;
        w.cond   = CondMoreCmds;
        w.target = PcCmd;
      end
      PcWidth'(8):  w.src = SrcCrcHi;
      PcWidth'(9):  begin w.src = SrcCrcLo; w.last = 1'b1; end
      PcWidth'(10): begin w.src = SrcZero;  w.last = 1'b1; w.err = 1'b1; end
      default:      w.src = SrcZero;
    endcase
    // Only the two closing steps end the run; every other step goes on.
    w.done = w.last;
    return w;
  endfunction

  // Byte-wise CRC-16, MSB first.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CrcPoly) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

@@ rtl/command_frame_builder_crc16.sv @@
// Start loads the step counter and run flag, and each byte then passes through
// the output register. A frame goes out one byte a cycle from the microcode step
// counter; no new request is taken until the frame or error word is done.
// The receiver cannot stall: each byte stands for one cycle under frame_valid_o.
// Reset (rst_ni low, asynchronous) stops any frame and restores the addresses.
module command_frame_builder_crc16 import cfb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_index_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic [3:0]  command_count_i,
  input  logic [7:0]  command_0_i,
  input  logic [7:0]  command_1_i,
  input  logic [7:0]  command_2_i,
  input  logic [7:0]  command_3_i,
  input  logic [7:0]  command_4_i,
  input  logic [7:0]  command_5_i,
  input  logic [7:0]  command_6_i,
  input  logic [7:0]  command_7_i,
  input  logic [7:0]  command_8_i,
  input  logic [7:0]  command_9_i,
  output logic        frame_valid_o,
  output logic [7:0]  frame_byte_o,
  output logic        frame_last_o,
  output logic        count_error_o
);

  logic [15:0]        dst_addr_q;
  logic [7:0]         src_addr_q;
  logic               run_q, run_d;
  logic [PcWidth-1:0] pc_q, pc_d;
  logic [3:0]         count_q;
  logic [3:0]         rem_q, rem_d;
  logic [7:0]         cmd_q [CmdFields];
  logic [15:0]        crc_q, crc_d;
  logic               valid_q;
  logic [7:0]         byte_q, byte_d;
  logic               last_q, err_q;
  logic               accept;
  logic               count_bad;
  logic               take_jump;
  logic [15:0]        crc_out;
  ctrl_t              ctrl;

  assign accept    = start && !busy;
  assign count_bad = (command_count_i == 4'd0) || (command_count_i > 4'(MaxCommands));
  assign busy      = run_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dst_addr_q <= DstAddrReset;
      src_addr_q <= SrcAddrReset;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        RegDstAddr: dst_addr_q <= cfg_wdata_i;
        RegSrcAddr: src_addr_q <= cfg_wdata_i[7:0];
        default:    ;
      endcase
    end
  end

  // Control word of the current step.
  always_comb begin
    ctrl = ucode_rom(pc_q);
  end

  // Step counter, remaining identifiers and run flag.
  always_comb begin
    run_d     = run_q;
    pc_d      = pc_q;
    rem_d     = rem_q;
    take_jump = (ctrl.cond == CondMoreCmds) && (rem_q != 4'd1);
    if (accept) begin
      run_d = 1'b1;
      pc_d  = count_bad ? PcError : PcFrame;
      rem_d = command_count_i;
    end else if (run_q) begin
      if (ctrl.shift) begin
        rem_d = rem_q - 4'd1;
      end
      if (ctrl.done) begin
        run_d = 1'b0;
      end else if (take_jump) begin
        pc_d = ctrl.target;
      end else begin
        pc_d = pc_q + PcWidth'(1);
      end
    end
  end

  // Byte selection and CRC update.
  always_comb begin
    crc_out = crc_q ^ CrcXorOut;
    case (ctrl.src)
      SrcDelim:   byte_d = StartDelim;
      SrcLen:     byte_d = LenBase + {4'd0, count_q};
      SrcDstHi:   byte_d = dst_addr_q[15:8];
      SrcDstLo:   byte_d = dst_addr_q[7:0];
      SrcSrcAddr: byte_d = src_addr_q;
      SrcClass:   byte_d = ClassByte;
      SrcOp:      byte_d = OpSet | {4'd0, count_q};
      SrcCmd:     byte_d = cmd_q[0];
      SrcCrcHi:   byte_d = crc_out[15:8];
      SrcCrcLo:   byte_d = crc_out[7:0];
      default:    byte_d = 8'h00;
    endcase
    crc_d = crc_q;
    if (accept) begin
      crc_d = CrcInit;
    end else if (run_q && ctrl.crc_en) begin
      crc_d = crc16_byte(crc_q, byte_d);
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q   <= 1'b0;
      pc_q    <= PcFrame;
      valid_q <= 1'b0;
    end else begin
      run_q   <= run_d;
      pc_q    <= pc_d;
      valid_q <= run_q;
    end
  end

  // Request payload: the identifiers shift toward slot 0 as they are sent.
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    crc_q <= crc_d;
    if (accept) begin
      count_q   <= command_count_i;
      cmd_q[0]  <= command_0_i;
      cmd_q[1]  <= command_1_i;
      cmd_q[2]  <= command_2_i;
      cmd_q[3]  <= command_3_i;
      cmd_q[4]  <= command_4_i;
      cmd_q[5]  <= command_5_i;
      cmd_q[6]  <= command_6_i;
      cmd_q[7]  <= command_7_i;
      cmd_q[8]  <= command_8_i;
      cmd_q[9]  <= command_9_i;
    end else if (run_q && ctrl.shift) begin
      for (int i = 0; i < CmdFields - 1; i++) begin
        cmd_q[i] <= cmd_q[i+1];
      end
    end
  end

  // Output register for the word of the current step.
  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    last_q <= ctrl.last;
    err_q  <= ctrl.err;
  end

  assign frame_valid_o = valid_q;
  assign frame_byte_o  = byte_q;
  assign frame_last_o  = last_q;
  assign count_error_o = err_q;

endmodule

@@ rtl/cfb_checker.sv @@
module cfb_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic       frame_valid_o,
  input logic [7:0] frame_byte_o,
  input logic       frame_last_o,
  input logic       count_error_o
);

  // An error word is a lone zero byte that closes the result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_valid_o && count_error_o |-> frame_last_o && (frame_byte_o == 8'h00))
    else $error("error word malformed");

  // A frame streams without gaps until its last byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_valid_o && !frame_last_o |=> frame_valid_o && !count_error_o)
    else $error("gap or error inside a frame");

  // The cycle after a last byte carries no word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_valid_o && frame_last_o |=> !frame_valid_o)
    else $error("word right after last byte");

  // A taken request shows its first word after the run flag and then the output register are loaded.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |-> ##2 frame_valid_o)
    else $error("first word missing");

  // The block is busy after it takes a request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("busy not raised");

endmodule

bind command_frame_builder_crc16 cfb_checker u_cfb_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .frame_valid_o (frame_valid_o),
  .frame_byte_o  (frame_byte_o),
  .frame_last_o  (frame_last_o),
  .count_error_o (count_error_o)
);

@@ verif/command_frame_builder_crc16_tb.sv @@
`timescale 1ns / 1ps

module command_frame_builder_crc16_tb;
  import cfb_pkg::*;

  // Cycles with neither a request taken nor a frame word seen before giving up.
  localparam int unsigned QuietLimit = 2000;
  localparam int unsigned ItemsPerSetting = 25;

  // One frame word as it appears on the result ports.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       err;
  } frame_word_t;

  // One request; expect_reject marks a row whose single error word is typed in.
  typedef struct packed {
    logic [3:0]      count;
    logic [9:0][7:0] cmds;
    logic            expect_reject;
  } request_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic        cfg_we_i;
  logic [0:0]  cfg_index_i;
  logic [15:0] cfg_wdata_i;
  logic [3:0]  command_count_i;
  logic [7:0]  command_0_i;
  logic [7:0]  command_1_i;
  logic [7:0]  command_2_i;
  logic [7:0]  command_3_i;
  logic [7:0]  command_4_i;
  logic [7:0]  command_5_i;
  logic [7:0]  command_6_i;
  logic [7:0]  command_7_i;
  logic [7:0]  command_8_i;
  logic [7:0]  command_9_i;
  logic        frame_valid_o;
  logic [7:0]  frame_byte_o;
  logic        frame_last_o;
  logic        count_error_o;

  // Frame words still owed by the block, oldest first.
  frame_word_t expected_frame_q [$];

  // Local copy of the address registers.
  logic [15:0] dst_addr_shadow;
  logic [7:0]  src_addr_shadow;

  request_t    directed_tbl [16];
  bit          idle_on;
  int unsigned fail_count;
  int unsigned requests_sent;
  int unsigned rejects_sent;
  int unsigned words_checked;
  int unsigned settings_used;
  int unsigned quiet_cycles;

  command_frame_builder_crc16 uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .command_count_i(command_count_i),
    .command_0_i    (command_0_i),
    .command_1_i    (command_1_i),
    .command_2_i    (command_2_i),
    .command_3_i    (command_3_i),
    .command_4_i    (command_4_i),
    .command_5_i    (command_5_i),
    .command_6_i    (command_6_i),
    .command_7_i    (command_7_i),
    .command_8_i    (command_8_i),
    .command_9_i    (command_9_i),
    .frame_valid_o  (frame_valid_o),
    .frame_byte_o   (frame_byte_o),
    .frame_last_o   (frame_last_o),
    .count_error_o  (count_error_o)
  );

  // Free-running clock, 2 ns period.
  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // CRC-16 over one byte, one bit at a time, MSB first.
  function automatic logic [15:0] crc16_step(input logic [15:0] acc, input logic [7:0] octet);
    logic [15:0] r;
    logic        fb;
    r = acc;
    for (int k = 7; k >= 0; k--) begin
      fb = r[15] ^ octet[k];
      r  = {r[14:0], 1'b0} ^ (fb ? CrcPoly : 16'h0000);
    end
    return r;
  endfunction

  // Work out the frame words a request produces and queue them.
  function automatic void predict_frame(input request_t req);
    logic [7:0]  pkt [$];
    logic [15:0] crc;
    if (req.count == 4'd0 || req.count > MaxCommands) begin
      expected_frame_q.push_back('{8'h00, 1'b1, 1'b1});
      return;
    end
    pkt.push_back(StartDelim);
    pkt.push_back(LenBase + {4'h0, req.count});
    pkt.push_back(dst_addr_shadow[15:8]);
    pkt.push_back(dst_addr_shadow[7:0]);
    pkt.push_back(src_addr_shadow);
    pkt.push_back(ClassByte);
    pkt.push_back(OpSet | {4'h0, req.count});
    for (int i = 0; i < req.count; i++) pkt.push_back(req.cmds[i]);
    // The delimiter is not covered by the CRC.
    crc = CrcInit;
    for (int i = 1; i < pkt.size(); i++) crc = crc16_step(crc, pkt[i]);
    crc = crc ^ CrcXorOut;
    pkt.push_back(crc[15:8]);
    pkt.push_back(crc[7:0]);
    for (int i = 0; i < pkt.size(); i++) begin
      expected_frame_q.push_back('{pkt[i], (i == pkt.size() - 1), 1'b0});
    end
  endfunction

  // Mostly valid counts with random identifiers; the rest are bad counts.
  function automatic request_t random_request();
    request_t    req;
    int unsigned pick;
    req.expect_reject = 1'b0;
    if ($urandom_range(99) < 85) begin
      req.count = 4'($urandom_range(1, MaxCommands));
    end else begin
      pick = $urandom_range(0, 5);
      req.count = (pick == 0) ? 4'd0 : 4'(10 + pick);
    end
    for (int k = 0; k < 10; k++) req.cmds[k] = 8'($urandom);
    return req;
  endfunction

  // Put random junk on the count port and some identifier ports while start is low.
  task automatic scramble_fields();
    command_count_i <= 4'($urandom);
    command_0_i     <= 8'($urandom);
    command_5_i     <= 8'($urandom);
    command_9_i     <= 8'($urandom);
  endtask

  // Present one request until it is taken, then queue its frame. While idle_on is set, a cycle in
  // which the block could take a request is left idle about 36 times in 100.
  task automatic send_request(input request_t req);
    bit taken;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      if (!busy && idle_on && $urandom_range(99) < 36) begin
        start <= 1'b0;
        scramble_fields();
      end else begin
        start           <= 1'b1;
        command_count_i <= req.count;
        command_0_i     <= req.cmds[0];
        command_1_i     <= req.cmds[1];
        command_2_i     <= req.cmds[2];
        command_3_i     <= req.cmds[3];
        command_4_i     <= req.cmds[4];
        command_5_i     <= req.cmds[5];
        command_6_i     <= req.cmds[6];
        command_7_i     <= req.cmds[7];
        command_8_i     <= req.cmds[8];
        command_9_i     <= req.cmds[9];
      end
      @(posedge clk_i);
      taken = start && !busy;
    end
    if (req.expect_reject) begin
      expected_frame_q.push_back('{8'h00, 1'b1, 1'b1});
    end else begin
      predict_frame(req);
    end
    requests_sent++;
    if (req.count == 4'd0 || req.count > MaxCommands) rejects_sent++;
  endtask

  // Write one address register once the block has drained.
  task automatic write_reg(input cfg_reg_e idx, input logic [15:0] value);
    @(negedge clk_i);
    start <= 1'b0;
    while (expected_frame_q.size() != 0 || busy) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    if (idx == RegDstAddr) begin
      dst_addr_shadow = value;
    end else begin
      src_addr_shadow = value[7:0];
    end
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= 16'($urandom);
  endtask

  // Compare every frame word with the oldest one still owed.
  always @(posedge clk_i) begin
    frame_word_t got;
    frame_word_t want;
    if (rst_ni && frame_valid_o) begin
      got = '{frame_byte_o, frame_last_o, count_error_o};
      if (expected_frame_q.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("ERROR: unexpected word byte=%02h last=%0b err=%0b",
                   got.data, got.last, got.err);
        end
      end else begin
        want = expected_frame_q.pop_front();
        words_checked++;
        if (got.data !== want.data || got.last !== want.last || got.err !== want.err) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("ERROR: word mismatch: expected byte=%02h last=%0b err=%0b,",
                     want.data, want.last, want.err,
                     " got byte=%02h last=%0b err=%0b",
                     got.data, got.last, got.err);
          end
        end
      end
    end
  end

  // Watchdog on cycles where nothing moves.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || frame_valid_o) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
        $display("Timeout: no activity for %0d cycles", QuietLimit);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Directed requests, then random ones under several address settings.
  initial begin
    logic [15:0] dst_val;
    logic [15:0] src_val;
    rst_ni          = 1'b0;
    start           = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_index_i     = 1'b0;
    cfg_wdata_i     = 16'h0000;
    command_count_i = 4'h0;
    command_0_i     = 8'h00;
    command_1_i     = 8'h00;
    command_2_i     = 8'h00;
    command_3_i     = 8'h00;
    command_4_i     = 8'h00;
    command_5_i     = 8'h00;
    command_6_i     = 8'h00;
    command_7_i     = 8'h00;
    command_8_i     = 8'h00;
    command_9_i     = 8'h00;
    dst_addr_shadow = DstAddrReset;
    src_addr_shadow = SrcAddrReset;
    fail_count      = 0;
    requests_sent   = 0;
    rejects_sent    = 0;
    words_checked   = 0;
    settings_used   = 1;
    quiet_cycles    = 0;
    idle_on         = 1'b1;

    // Count extremes, identifier extremes, ignored identifiers and bad counts.
    directed_tbl = '{
      '{4'd1,  {10{8'h00}}, 1'b0},
      '{4'd1,  {10{8'hFF}}, 1'b0},
      '{4'd10, {10{8'h00}}, 1'b0},
      '{4'd10, {10{8'hFF}}, 1'b0},
      '{4'd10, {5{16'hAA55}}, 1'b0},
      '{4'd10, {5{16'h55AA}}, 1'b0},
      '{4'd0,  {10{8'hFF}}, 1'b1},
      '{4'd11, {10{8'h00}}, 1'b1},
      '{4'd15, 80'h09080706050403020100, 1'b1},
      '{4'd12, {10{8'hA5}}, 1'b1},
      '{4'd3,  {{7{8'hFF}}, 8'h56, 8'h34, 8'h12}, 1'b0},
      '{4'd5,  80'h09080706050403020100, 1'b0},
      '{4'd9,  {8'hFF, {9{8'h3C}}}, 1'b0},
      '{4'd7,  80'h0123456789ABCDEF0123, 1'b0},
      '{4'd2,  {10{8'h00}}, 1'b0},
      '{4'd8,  80'hFEDCBA9876543210FEDC, 1'b0}
    };

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_tbl[i]) send_request(directed_tbl[i]);

    // Each setting: zero, all ones, random, reset values with wide source data.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          dst_val = 16'h0000;
          src_val = 16'h0000;
        end
        1: begin
          dst_val = 16'hFFFF;
          src_val = 16'hFFFF;
        end
        2: begin
          dst_val = 16'($urandom);
          src_val = 16'($urandom);
        end
        default: begin
          dst_val = DstAddrReset;
          src_val = {8'hC3, SrcAddrReset};
        end
      endcase
      write_reg(RegDstAddr, dst_val);
      write_reg(RegSrcAddr, src_val);
      settings_used++;
      // One whole setting, the random one, is sent with no idle cycles inserted.
      idle_on = (phase != 2);
      repeat (ItemsPerSetting) send_request(random_request());
    end

    // Drain the last frame, then watch a little longer for stray words.
    @(negedge clk_i);
    start <= 1'b0;
    while (expected_frame_q.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);

    $display("Sent %0d requests (%0d with a bad count) across %0d address settings.",
             requests_sent, rejects_sent, settings_used);
    $display("Checked %0d frame words; %0d failures.", words_checked, fail_count);
    if (fail_count == 0 && expected_frame_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
